### hdl/mp2a_pkg.sv
// Shared types and codes for the 2-D max pooling with argmax block.
`timescale 1ns / 1ps
package mp2a_pkg;

    typedef enum logic [7:0] {
        CFG_IN_WIDTH  = 8'd0,
        CFG_IN_HEIGHT = 8'd1,
        CFG_WINDOW    = 8'd2,
        CFG_STRIDE    = 8'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [1:0] count;
    } t_fifo_stat;

endpackage

### hdl/mp2a_out_fifo.sv
// Two-entry result buffer between the merge stage and the output stream.
`timescale 1ns / 1ps
module mp2a_out_fifo #(
    parameter int DW = 80
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic [DW-1:0]         i_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [DW-1:0]         o_data,
    output mp2a_pkg::t_fifo_stat  o_stat
);
    import mp2a_pkg::*;

    logic [DW-1:0] r_mem [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    logic          pop;

    assign o_valid      = (r_cnt != 2'd0);
    assign pop          = o_valid && i_ready;
    assign o_data       = r_mem[r_rp];
    assign o_stat.count = r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            case ({i_push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

endmodule

### hdl/max_pool_2d_argmax.sv
// Top level: streaming 2-D max pooling with argmax over line memories.
`timescale 1ns / 1ps
// Takes one sample per cycle in raster order while the output buffer has room,
// plane after plane, and emits one item per finished pooling window: the
// maximum, the global index of its first occurrence, a found flag in tuser, the
// output row and column, and tlast on the last window of a plane. Each sample
// passes two stages: the first updates the horizontal segment registers and
// reads the line memory row of the column window that ends at this sample, the
// second merges the segment into that row, writes it back and pushes a result
// into a two-entry output buffer. Back-to-back accesses to the same line memory
// row are forwarded. The line memory holds MAX_WIDTH rows of MAX_WINDOW lanes
// and needs no clearing pass: every entry is written by the first row of its
// window before it is read. Configuration writes restart the plane and must be
// issued only while no item is in flight.
module max_pool_2d_argmax #(
    parameter int MAX_WIDTH   = 1024,
    parameter int MAX_WINDOW  = 8,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // sample
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      i_s_axis_tdata,
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // max_value, max_index, out_row, out_col
    output logic [((SAMPLE_BITS+58+7)/8)*8-1:0]   o_m_axis_tdata,
    // index_found
    output logic                                  o_m_axis_tuser,
    output logic                                  o_m_axis_tlast,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [7:0]                            i_cfg_index,
    input  logic [15:0]                           i_cfg_data
);
    import mp2a_pkg::*;

    localparam int SB  = SAMPLE_BITS;
    localparam int MW  = MAX_WINDOW;
    localparam int LW  = $clog2(MAX_WINDOW);
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int LE  = SB + 33;
    localparam int PW  = SB + 58;
    localparam int ODW = ((SB + 58 + 7) / 8) * 8;
    localparam int FW  = PW + 2;
    localparam logic signed [SB-1:0] MOST_NEG = {1'b1, {(SB-1){1'b0}}};

    typedef struct packed {
        logic [MW-1:0] cov;
        logic [MW-1:0] first;
        logic          hit;
        logic [15:0]   win;
        logic [LW-1:0] lane;
        logic          in_plane;
    } t_axis;

    function automatic t_axis f_axis(input logic [15:0] pos, input logic [3:0] ph,
                                     input logic [15:0] q, input logic [LW-1:0] lq,
                                     input logic [16:0] dim, input logic [4:0] k,
                                     input logic [3:0] s);
        t_axis               a;
        logic [7:0]          ds;
        logic [16:0]         st;
        logic [8:0]          off;
        logic [MW-1:0]       okd;
        logic [MW-1:0][LW-1:0] lnd;
        logic                cv;
        logic                found;
        int                  li;
        a     = '0;
        okd   = '0;
        lnd   = '0;
        found = 1'b0;
        for (int d = 0; d < MW; d++) begin
            ds  = 8'(d) * {4'd0, s};
            off = {5'd0, ph} + {1'b0, ds};
            st  = 17'(pos) - 17'(ph) - 17'(ds);
            li  = (int'(lq) >= d) ? int'(lq) - d : int'(lq) + MW - d;
            lnd[d] = LW'(li);
            cv  = (16'(d) <= q) && (off < {4'd0, k});
            okd[d] = cv && ((st == 17'd0) || (st + 17'(k) < dim + 17'(s)));
            if (okd[d]) begin
                a.cov[lnd[d]] = 1'b1;
                if (d == 0 && ph == 4'd0) a.first[lnd[d]] = 1'b1;
            end
            if (cv && off == {4'd0, k} - 9'd1) begin
                a.hit      = 1'b1;
                a.win      = q - 16'(d);
                a.lane     = lnd[d];
                a.in_plane = 1'b1;
            end
        end
        if ({1'b0, pos} == dim - 17'd1) begin
            a.hit = 1'b1;
            if (17'(pos) - 17'(ph) + 17'(k) < dim) begin
                a.win      = q + 16'd1;
                a.lane     = (lq == LW'(MW - 1)) ? '0 : lq + LW'(1);
                a.in_plane = 1'b0;
            end else begin
                for (int d = 0; d < MW; d++) begin
                    if (!found && okd[d]) begin
                        found      = 1'b1;
                        a.win      = q - 16'(d);
                        a.lane     = lnd[d];
                        a.in_plane = 1'b1;
                    end
                end
            end
        end
        return a;
    endfunction

    // configuration
    logic [10:0] r_in_width;
    logic [15:0] r_in_height;
    logic [3:0]  r_window;
    logic [3:0]  r_stride;
    logic [16:0] w;
    logic [16:0] h;
    logic [4:0]  k;
    logic [3:0]  s;
    logic        cfg_hit;

    // position
    logic [CW-1:0] r_col;
    logic [3:0]    r_phc;
    logic [CW-1:0] r_qc;
    logic [LW-1:0] r_lqc;
    logic [15:0]   r_row;
    logic [3:0]    r_phr;
    logic [15:0]   r_qr;
    logic [LW-1:0] r_lqr;
    logic [31:0]   r_idx;

    logic signed [SB-1:0] r_seg_max [MW];
    logic [32:0]          r_seg_idx [MW];
    logic signed [SB-1:0] n_seg_max [MW];
    logic [32:0]          n_seg_idx [MW];

    t_axis                ax_c;
    t_axis                ax_r;
    logic                 in_acc;
    logic signed [SB-1:0] val;
    logic signed [SB-1:0] smax;
    logic [32:0]          sidx;
    logic                 last_col;
    logic                 last_row;

    // stage 1
    logic                 r_s1_valid;
    logic                 r_s1_idone;
    logic                 r_s1_iin;
    logic [LW-1:0]        r_s1_ilane;
    logic [CW-1:0]        r_s1_addr;
    logic signed [SB-1:0] r_s1_smax;
    logic [32:0]          r_s1_sidx;
    logic [MW-1:0]        r_s1_first;
    logic [MW-1:0]        r_s1_merge;
    logic [15:0]          r_s1_iend;
    logic [9:0]           r_s1_jend;
    logic                 r_s1_pend;
    logic                 r_s1_fwd;

    logic [MW-1:0][LE-1:0] r_line [MAX_WIDTH];
    logic [MW-1:0][LE-1:0] r_rdata;
    logic [MW-1:0][LE-1:0] r_fwd_row;
    logic [MW-1:0][LE-1:0] row_in;
    logic [MW-1:0][LE-1:0] n_row;

    logic [LE-1:0]        ent;
    logic                 o_found;
    logic [FW-1:0]        push_data;
    logic [FW-1:0]        fifo_data;
    logic                 push;
    logic                 pop;
    t_fifo_stat           fifo_stat;

    assign w = (r_in_width == 11'd0) ? 17'd1 :
               ((17'(r_in_width) > 17'(MAX_WIDTH)) ? 17'(MAX_WIDTH) : 17'(r_in_width));
    assign h = (r_in_height == 16'd0) ? 17'd1 : 17'(r_in_height);
    assign k = (r_window == 4'd0) ? 5'd1 :
               ((5'(r_window) > 5'(MW)) ? 5'(MW) : 5'(r_window));
    assign s = (r_stride == 4'd0) ? 4'd1 : r_stride;

    assign o_cfg_ready = 1'b1;
    assign cfg_hit = i_cfg_valid && (i_cfg_index == CFG_IN_WIDTH || i_cfg_index == CFG_IN_HEIGHT
                     || i_cfg_index == CFG_WINDOW || i_cfg_index == CFG_STRIDE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_width  <= 11'd32;
            r_in_height <= 16'd32;
            r_window    <= 4'd2;
            r_stride    <= 4'd2;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_IN_WIDTH:  r_in_width  <= i_cfg_data[10:0];
                CFG_IN_HEIGHT: r_in_height <= i_cfg_data;
                CFG_WINDOW:    r_window    <= i_cfg_data[3:0];
                CFG_STRIDE:    r_stride    <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    assign push = r_s1_valid && r_s1_idone;
    assign pop  = o_m_axis_tvalid && i_m_axis_tready;
    assign o_s_axis_tready = ({1'b0, fifo_stat.count} + {2'd0, push}) < (3'd2 + {2'd0, pop});
    assign in_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign val    = $signed(i_s_axis_tdata[SB-1:0]);

    assign ax_c = f_axis(16'(r_col), r_phc, 16'(r_qc), r_lqc, w, k, s);
    assign ax_r = f_axis(r_row, r_phr, r_qr, r_lqr, h, k, s);
    assign last_col = ({1'b0, 16'(r_col)} == w - 17'd1);
    assign last_row = ({1'b0, r_row} == h - 17'd1);

    always_comb begin
        for (int l = 0; l < MW; l++) begin
            n_seg_max[l] = r_seg_max[l];
            n_seg_idx[l] = r_seg_idx[l];
            if (ax_c.cov[l]) begin
                if (ax_c.first[l]) begin
                    n_seg_max[l] = MOST_NEG;
                    n_seg_idx[l] = 33'd0;
                end
                if (val > n_seg_max[l]) begin
                    n_seg_max[l] = val;
                    n_seg_idx[l] = {1'b1, r_idx};
                end
            end
        end
        smax = ax_c.in_plane ? n_seg_max[ax_c.lane] : MOST_NEG;
        sidx = ax_c.in_plane ? n_seg_idx[ax_c.lane] : 33'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_phc <= '0;
            r_qc  <= '0;
            r_lqc <= '0;
            r_row <= '0;
            r_phr <= '0;
            r_qr  <= '0;
            r_lqr <= '0;
            r_idx <= '0;
            for (int l = 0; l < MW; l++) begin
                r_seg_max[l] <= MOST_NEG;
                r_seg_idx[l] <= 33'd0;
            end
        end else if (cfg_hit) begin
            r_col <= '0;
            r_phc <= '0;
            r_qc  <= '0;
            r_lqc <= '0;
            r_row <= '0;
            r_phr <= '0;
            r_qr  <= '0;
            r_lqr <= '0;
        end else if (in_acc) begin
            r_idx <= r_idx + 32'd1;
            for (int l = 0; l < MW; l++) begin
                r_seg_max[l] <= n_seg_max[l];
                r_seg_idx[l] <= n_seg_idx[l];
            end
            if (last_col) begin
                r_col <= '0;
                r_phc <= '0;
                r_qc  <= '0;
                r_lqc <= '0;
                if (last_row) begin
                    r_row <= '0;
                    r_phr <= '0;
                    r_qr  <= '0;
                    r_lqr <= '0;
                end else begin
                    r_row <= r_row + 16'd1;
                    if (r_phr + 4'd1 == s) begin
                        r_phr <= '0;
                        r_qr  <= r_qr + 16'd1;
                        r_lqr <= (r_lqr == LW'(MW - 1)) ? '0 : r_lqr + LW'(1);
                    end else begin
                        r_phr <= r_phr + 4'd1;
                    end
                end
            end else begin
                r_col <= r_col + CW'(1);
                if (r_phc + 4'd1 == s) begin
                    r_phc <= '0;
                    r_qc  <= r_qc + CW'(1);
                    r_lqc <= (r_lqc == LW'(MW - 1)) ? '0 : r_lqc + LW'(1);
                end else begin
                    r_phc <= r_phc + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_fwd   <= 1'b0;
        end else begin
            r_s1_valid <= in_acc && ax_c.hit;
            r_s1_fwd   <= in_acc && r_s1_valid && (r_s1_addr == ax_c.win[CW-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_idone <= ax_r.hit;
            r_s1_iin   <= ax_r.in_plane;
            r_s1_ilane <= ax_r.lane;
            r_s1_addr  <= ax_c.win[CW-1:0];
            r_s1_smax  <= smax;
            r_s1_sidx  <= sidx;
            r_s1_first <= ax_r.first;
            r_s1_merge <= ax_r.cov & ~ax_r.first;
            r_s1_iend  <= ax_r.win;
            r_s1_jend  <= ax_c.win[9:0];
            r_s1_pend  <= last_col && last_row;
        end
        r_fwd_row <= n_row;
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) r_line[r_s1_addr] <= n_row;
        if (in_acc) r_rdata <= r_line[ax_c.win[CW-1:0]];
    end

    assign row_in = r_s1_fwd ? r_fwd_row : r_rdata;

    always_comb begin
        for (int l = 0; l < MW; l++) begin
            n_row[l] = row_in[l];
            if (r_s1_first[l]) begin
                n_row[l] = {r_s1_sidx, r_s1_smax};
            end else if (r_s1_merge[l] && r_s1_sidx[32]
                         && r_s1_smax > $signed(row_in[l][SB-1:0])) begin
                n_row[l] = {r_s1_sidx, r_s1_smax};
            end
        end
        ent     = r_s1_iin ? n_row[r_s1_ilane] : {33'd0, MOST_NEG};
        o_found = ent[LE-1];
        push_data = {o_found, r_s1_pend, r_s1_jend, r_s1_iend,
                     o_found ? ent[SB+31:SB] : 32'hFFFF_FFFF,
                     o_found ? ent[SB-1:0] : MOST_NEG};
    end

    mp2a_out_fifo #(
        .DW(FW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (fifo_data),
        .o_stat  (fifo_stat)
    );

    assign o_m_axis_tdata = ODW'(fifo_data[PW-1:0]);
    assign o_m_axis_tlast = fifo_data[PW];
    assign o_m_axis_tuser = fifo_data[PW+1];

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (fifo_stat.count != 2'd2 || pop))
        else $error("result buffer overflow");

    a_fwd_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_fwd |-> $past(r_s1_valid))
        else $error("forward without a prior line write");

    a_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser) |->
        (o_m_axis_tdata[SB+31:SB] == 32'hFFFF_FFFF && o_m_axis_tdata[SB-1:0] == MOST_NEG))
        else $error("empty window carries a value");
`endif

endmodule

### tb/testbench.sv
// Self-checking testbench for the streaming 2-D max pooling with argmax block.
`timescale 1ns / 1ps
module testbench;
    import mp2a_pkg::*;

    localparam int MAXW = 1024;
    localparam int MAXK = 8;
    localparam int WDOG_LIMIT = 20000;

    typedef struct packed {
        logic [15:0] value;
        logic [31:0] index;
        logic        found;
        logic [15:0] row;
        logic [9:0]  col;
        logic        last;
    } t_pool_out;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_s_axis_tvalid = 0;
    logic        o_s_axis_tready;
    logic [15:0] i_s_axis_tdata = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 0;
    logic [79:0] o_m_axis_tdata;
    logic        o_m_axis_tuser;
    logic        o_m_axis_tlast;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    max_pool_2d_argmax u_top (.*);

    initial forever #5 i_clk = ~i_clk;

    // predictor state
    int unsigned cfg_w, cfg_h, cfg_k, cfg_s;
    int unsigned row_pos, col_pos, pix_cnt;
    logic signed [15:0] seg_max [MAXK];
    logic [32:0]        seg_idx [MAXK];
    logic signed [15:0] line_max [MAXK*MAXW];
    logic [32:0]        line_idx [MAXK*MAXW];

    t_pool_out pending_windows[$];
    int errors = 0;
    int n_samples = 0, n_windows = 0, n_cfg = 0;
    int idle_pct = 22;
    int wdog = 0;

    task automatic report(input string what, input longint got, input longint want);
        errors++;
        $display("mismatch %0s: got %0h expected %0h at %0t", what, got, want, $time);
    endtask

    function automatic int unsigned out_len(int unsigned d, int unsigned k, int unsigned s);
        if (d <= k) return 1;
        return (d - k + s - 1) / s + 1;
    endfunction

    function automatic bit ending(int unsigned p, int unsigned lastp, int unsigned k,
                                  int unsigned s, int unsigned n, output int unsigned w);
        w = 0;
        if (p == lastp) begin
            w = n - 1;
            return 1;
        end
        if (p + 1 < k || ((p + 1 - k) % s) != 0) return 0;
        if ((p + 1 - k) / s >= n) return 0;
        w = (p + 1 - k) / s;
        return 1;
    endfunction

    task automatic pool_predict(input logic signed [15:0] v);
        int unsigned w, h, k, s, ow, oh, r, c, lo, hi, je, ie, a;
        logic signed [15:0] sm, m;
        logic [32:0] si, x;
        t_pool_out o;
        w = cfg_w == 0 ? 1 : (cfg_w > MAXW ? MAXW : cfg_w);
        h = cfg_h == 0 ? 1 : cfg_h;
        k = cfg_k == 0 ? 1 : (cfg_k > MAXK ? MAXK : cfg_k);
        s = cfg_s == 0 ? 1 : cfg_s;
        ow = out_len(w, k, s);
        oh = out_len(h, k, s);
        r = row_pos;
        c = col_pos;
        sm = 16'sh8000;
        si = '0;
        lo = c >= k ? (c - k + s) / s : 0;
        hi = c / s;
        if (hi > ow - 1) hi = ow - 1;
        for (int unsigned j = lo; j <= hi; j++) begin
            if (c == j * s) begin
                seg_max[j % MAXK] = 16'sh8000;
                seg_idx[j % MAXK] = '0;
            end
            if (v > seg_max[j % MAXK]) begin
                seg_max[j % MAXK] = v;
                seg_idx[j % MAXK] = {1'b1, pix_cnt};
            end
        end
        if (ending(c, w - 1, k, s, ow, je)) begin
            if (je * s < w) begin
                sm = seg_max[je % MAXK];
                si = seg_idx[je % MAXK];
            end
            lo = r >= k ? (r - k + s) / s : 0;
            hi = r / s;
            if (hi > oh - 1) hi = oh - 1;
            for (int unsigned i = lo; i <= hi; i++) begin
                a = (i % MAXK) * MAXW + je;
                if (r == i * s || (si[32] && sm > line_max[a])) begin
                    line_max[a] = sm;
                    line_idx[a] = si;
                end
            end
            if (ending(r, h - 1, k, s, oh, ie)) begin
                m = 16'sh8000;
                x = '0;
                if (ie * s < h) begin
                    a = (ie % MAXK) * MAXW + je;
                    m = line_max[a];
                    x = line_idx[a];
                end
                o.value = x[32] ? m : 16'h8000;
                o.index = x[32] ? x[31:0] : 32'hFFFF_FFFF;
                o.found = x[32];
                o.row = ie[15:0];
                o.col = je[9:0];
                o.last = (r == h - 1 && c == w - 1);
                pending_windows.push_back(o);
            end
        end
        pix_cnt++;
        if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
    endtask

    task automatic send_sample(input logic [15:0] v);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            i_s_axis_tvalid <= 0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1;
        i_s_axis_tdata <= v;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        pool_predict(v);
        n_samples++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 0;
        while (pending_windows.size() > 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input int unsigned val);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val[15:0];
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_IN_WIDTH:  cfg_w = val & 16'h7FF;
            CFG_IN_HEIGHT: cfg_h = val & 16'hFFFF;
            CFG_WINDOW:    cfg_k = val & 16'hF;
            CFG_STRIDE:    cfg_s = val & 16'hF;
            default: ;
        endcase
        if (idx inside {CFG_IN_WIDTH, CFG_IN_HEIGHT, CFG_WINDOW, CFG_STRIDE}) begin
            row_pos = 0;
            col_pos = 0;
        end
        n_cfg++;
        @(negedge i_clk);
        i_cfg_valid <= 0;
        @(negedge i_clk);
    endtask

    task automatic set_geometry(input int unsigned w, h, k, s);
        drain();
        write_reg(CFG_IN_WIDTH, w);
        write_reg(CFG_IN_HEIGHT, h);
        write_reg(CFG_WINDOW, k);
        write_reg(CFG_STRIDE, s);
    endtask

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom_range(3)) - 16'd2;
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic run_planes(input int planes, input int unsigned w, h, k, s);
        int unsigned ew, eh;
        set_geometry(w, h, k, s);
        ew = w == 0 ? 1 : (w > MAXW ? MAXW : w);
        eh = h == 0 ? 1 : h;
        for (int p = 0; p < planes; p++)
            for (int unsigned i = 0; i < ew * eh; i++) send_sample(rand_sample());
    endtask

    // extremes, all-most-negative windows, ties, truncated windows
    task automatic test_directed();
        logic [15:0] pat [16] = '{16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF,
                                  16'h8000, 16'h8000, 16'h0001, 16'hFFFF,
                                  16'h0000, 16'h0000, 16'h8000, 16'h5555,
                                  16'hAAAA, 16'h8000, 16'h8000, 16'h8000};
        foreach (pat[i]) send_sample(pat[i]);
        set_geometry(3, 3, 2, 2);
        for (int i = 0; i < 9; i++) send_sample(i == 4 ? 16'h8000 : 16'h8000);
    endtask

    task automatic test_register_corners();
        run_planes(1, 0, 0, 0, 0);
        run_planes(1, 2, 3, 8, 8);
        run_planes(1, 9, 9, 15, 15);
        run_planes(1, 2047, 1, 2, 2);
        run_planes(1, 5, 4, 3, 1);
        for (int i = 0; i < 3; i++) send_sample(rand_sample());
        drain();
        write_reg(t_cfg_reg'(8'd7), 16'hFFFF);
        for (int i = 0; i < 10; i++) send_sample(rand_sample());
    endtask

    task automatic test_random();
        int unsigned w, h, k, s;
        while (n_samples < 1750) begin
            k = $urandom_range(8, 1);
            s = $urandom_range(8, 1);
            w = $urandom_range(12, 1);
            h = $urandom_range(12, 1);
            if ($urandom_range(4) == 0) k = $urandom_range(15, 0);
            run_planes($urandom_range(2, 1), w, h, k, s);
        end
    endtask

    task automatic test_height_extreme();
        run_planes(1, 1, 100, 3, 2);
        set_geometry(1, 16'hFFFF, 2, 8);
        for (int i = 0; i < 40; i++) send_sample(rand_sample());
    endtask

    // output side: random stalls, one quiet stretch
    initial begin
        @(negedge i_clk);
        forever begin
            i_m_axis_tready <= (idle_pct == 0) || ($urandom_range(99) >= idle_pct);
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            t_pool_out e;
            if (pending_windows.size() == 0) begin
                report("unexpected window", o_m_axis_tdata[31:0], 0);
            end else begin
                e = pending_windows.pop_front();
                n_windows++;
                if (o_m_axis_tdata[15:0] !== e.value) report("max_value", o_m_axis_tdata[15:0], e.value);
                if (o_m_axis_tdata[47:16] !== e.index) report("max_index", o_m_axis_tdata[47:16], e.index);
                if (o_m_axis_tdata[63:48] !== e.row) report("out_row", o_m_axis_tdata[63:48], e.row);
                if (o_m_axis_tdata[73:64] !== e.col) report("out_col", o_m_axis_tdata[73:64], e.col);
                if (o_m_axis_tuser !== e.found) report("index_found", o_m_axis_tuser, e.found);
                if (o_m_axis_tlast !== e.last) report("plane_end", o_m_axis_tlast, e.last);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
            || (i_cfg_valid && o_cfg_ready))
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog >= WDOG_LIMIT) begin
            $display("watchdog expired with %0d windows outstanding", pending_windows.size());
            $display("max_pool_2d_argmax regression: fail");
            $finish;
        end
    end

    initial begin
        cfg_w = 32; cfg_h = 32; cfg_k = 2; cfg_s = 2;
        row_pos = 0; col_pos = 0; pix_cnt = 0;
        for (int t = 0; t < MAXK; t++) begin
            seg_max[t] = 16'sh8000;
            seg_idx[t] = '0;
        end
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        test_directed();
        drain();
        run_planes(1, 8, 8, 2, 2);
        test_register_corners();
        idle_pct = 0;
        run_planes(1, 12, 12, 3, 2);
        idle_pct = 22;
        test_height_extreme();
        test_random();
        drain();
        $display("covered %0d samples, %0d windows, %0d register writes", n_samples,
                 n_windows, n_cfg);
        if (errors == 0)
            $display("max_pool_2d_argmax regression: pass");
        else
            $display("max_pool_2d_argmax regression: fail");
        $finish;
    end
endmodule

### files.f
hdl/mp2a_pkg.sv
hdl/mp2a_out_fifo.sv
hdl/max_pool_2d_argmax.sv
tb/testbench.sv
